// ----- design/bb5_pkg.sv -----
// ----------------------------------------------------------------------------
// bb5_pkg
// Shared types and constants of the 5x5 box blur stream block.
// ----------------------------------------------------------------------------
package bb5_pkg;

	localparam int CH_W       = 8;
	localparam int NUM_CH     = 3;
	localparam int WIN        = 5;
	localparam int HALF       = WIN / 2;
	localparam int LANES      = WIN - 1;
	localparam int CFG_W      = 11;
	localparam int ROW_W      = 11;
	localparam int MIN_DIM    = 5;
	localparam int MAX_HEIGHT = 1024;
	localparam int WIDTH_RST  = 640;
	localparam int HEIGHT_RST = 480;

	// sum widths: 5 * 255 and 25 * 255
	localparam int COLSUM_W = 11;
	localparam int HSUM_W   = 13;

	// floor(s / 25) = (s * 5243) >> 17 for s < 43690
	localparam int DIV_MUL   = 5243;
	localparam int DIV_SHIFT = 17;
	localparam int PROD_W    = 26;

	typedef logic [CH_W-1:0] chan_t;
	typedef chan_t [NUM_CH-1:0] rgb_t;
	typedef rgb_t [LANES-1:0] col_t;
	typedef logic [NUM_CH-1:0][COLSUM_W-1:0] colsum_t;
	typedef logic [NUM_CH-1:0][HSUM_W-1:0] hsum_t;
	typedef logic [WIN-1:0] mask_t;

	typedef enum logic [0:0] {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic  valid;
		logic  emit;
		logic  eor;
		logic  eof;
		mask_t vmask;
		mask_t hmask;
	} ctrl_t;

	typedef struct packed {
		logic valid;
		logic eor;
		logic eof;
		rgb_t rgb;
	} res_t;

endpackage

// ----- design/bb5_line_store.sv -----
// ----------------------------------------------------------------------------
// bb5_line_store
// Column memory of the four previous rows; read on accept, the shifted
// column (new pixel in lane 0) is written back from stage 1 on the next advance.
// ----------------------------------------------------------------------------
module bb5_line_store #(
	parameter int MAX_WIDTH = 1024,
	localparam int AW = $clog2(MAX_WIDTH)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_en,
	input  logic [AW-1:0]      rd_addr,
	input  logic               wr_en,
	input  logic [AW-1:0]      wr_addr,
	input  bb5_pkg::rgb_t      wr_pix,
	output bb5_pkg::col_t      rd_col
);

	bb5_pkg::col_t mem [MAX_WIDTH];
	bb5_pkg::col_t wr_col;

	// oldest row drops out
	assign wr_col = {rd_col[bb5_pkg::LANES-2:0], wr_pix};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_col;
		end
		if (rd_en) begin
			rd_col <= mem[rd_addr];
		end
	end

	a_no_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && rd_en) |-> (wr_addr != rd_addr))
		else $error("line store read and write hit the same column");

endmodule

// ----- design/bb5_window.sv -----
// ----------------------------------------------------------------------------
// bb5_window
// Column sums, 5-tap horizontal window, masked sum and divide by 25.
// ----------------------------------------------------------------------------
module bb5_window (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  bb5_pkg::ctrl_t ctrl_s1,
	input  bb5_pkg::rgb_t  pix_s1,
	input  bb5_pkg::col_t  col_data,
	output bb5_pkg::res_t  res
);

	localparam int CSW = bb5_pkg::COLSUM_W;
	localparam int HSW = bb5_pkg::HSUM_W;
	localparam int PW  = bb5_pkg::PROD_W;
	localparam int DS  = bb5_pkg::DIV_SHIFT;
	localparam int CW  = bb5_pkg::CH_W;

	bb5_pkg::colsum_t colsum;
	bb5_pkg::colsum_t tap_q [bb5_pkg::WIN];
	bb5_pkg::hsum_t   hsum;
	bb5_pkg::hsum_t   sum_s3;
	logic [bb5_pkg::NUM_CH-1:0][PW-1:0] prod;

	logic            valid_s2, valid_s3, valid_s4;
	bb5_pkg::mask_t  hmask_s2;
	logic            eor_s2, eof_s2, eor_s3, eof_s3, eor_s4, eof_s4;
	bb5_pkg::rgb_t   rgb_s4;

	always_comb begin
		for (int ch = 0; ch < bb5_pkg::NUM_CH; ch++) begin
			colsum[ch] = ctrl_s1.vmask[0] ? CSW'(pix_s1[ch]) : '0;
			for (int k = 1; k < bb5_pkg::WIN; k++) begin
				if (ctrl_s1.vmask[k]) begin
					colsum[ch] = colsum[ch] + CSW'(col_data[k-1][ch]);
				end
			end
		end
	end

	always_comb begin
		for (int ch = 0; ch < bb5_pkg::NUM_CH; ch++) begin
			hsum[ch] = '0;
			for (int j = 0; j < bb5_pkg::WIN; j++) begin
				if (hmask_s2[j]) begin
					hsum[ch] = hsum[ch] + HSW'(tap_q[j][ch]);
				end
			end
		end
	end

	always_comb begin
		for (int ch = 0; ch < bb5_pkg::NUM_CH; ch++) begin
			prod[ch] = PW'(sum_s3[ch]) * PW'(bb5_pkg::DIV_MUL);
		end
	end

	// tap 0 holds the newest column
	always_ff @(posedge clk) begin
		if (adv) begin
			if (ctrl_s1.valid) begin
				tap_q[0] <= colsum;
				for (int j = 1; j < bb5_pkg::WIN; j++) begin
					tap_q[j] <= tap_q[j-1];
				end
			end
			hmask_s2 <= ctrl_s1.hmask;
			eor_s2   <= ctrl_s1.eor;
			eof_s2   <= ctrl_s1.eof;
			sum_s3   <= hsum;
			eor_s3   <= eor_s2;
			eof_s3   <= eof_s2;
			for (int ch = 0; ch < bb5_pkg::NUM_CH; ch++) begin
				rgb_s4[ch] <= prod[ch][DS +: CW];
			end
			eor_s4 <= eor_s3;
			eof_s4 <= eof_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= ctrl_s1.valid && ctrl_s1.emit;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	assign res.valid = valid_s4;
	assign res.eor   = eor_s4;
	assign res.eof   = eof_s4;
	assign res.rgb   = rgb_s4;

endmodule

// ----- design/bb5_out_skid.sv -----
// ----------------------------------------------------------------------------
// bb5_out_skid
// Output register plus one skid entry; the pipeline halts only when the
// skid entry is occupied.
// ----------------------------------------------------------------------------
module bb5_out_skid (
	input  logic          clk,
	input  logic          arst_n,
	input  bb5_pkg::res_t in_res,
	output logic          in_ready,
	input  logic          m_ready,
	output bb5_pkg::res_t out_res
);

	logic          out_valid_q, skid_valid_q;
	bb5_pkg::res_t out_q, skid_q;
	logic          take, load;

	assign in_ready = !skid_valid_q;
	assign take     = out_valid_q && m_ready;
	assign load     = in_ready && in_res.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (load) begin
			if (out_valid_q && !take) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (load) begin
			if (out_valid_q && !take) begin
				skid_q <= in_res;
			end else begin
				out_q <= in_res;
			end
		end
	end

	assign out_res.valid = out_valid_q;
	assign out_res.eor   = out_q.eor;
	assign out_res.eof   = out_q.eof;
	assign out_res.rgb   = out_q.rgb;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held while output register empty");

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !m_ready))
		else $error("skid entry filled without an output stall");

endmodule

// ----- design/box_blur_5x5_stream_top.sv -----
// ----------------------------------------------------------------------------
// box_blur_5x5_stream_top
// 5x5 box blur over an RGB pixel stream, zero outside the image.
//
// Pixels enter in raster order, one beat per clock sustained; s_tready drops
// only while the output skid entry is full. Each accepted pixel reads one
// column of the four previous rows from a MAX_WIDTH x 96 bit line memory and
// writes the shifted column back on the next advance, so the memory ports set
// the rate at one pixel per clock. A result passes the stage-1, tap, sum,
// divide and output registers after the beat that completes its window; the
// first result of a frame follows pixel 2*width+2, and 2*width+2 beats with
// s_tuser set (flush) drain the rest. A flush beat inside the frame is a
// black pixel. Writing image_width or image_height restarts the frame.
// ----------------------------------------------------------------------------
module box_blur_5x5_stream_top #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // red_in, green_in, blue_in
	input  logic        s_tuser,   // flush
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // red_out, green_out, blue_out
	output logic        m_tlast,   // end_of_row
	output logic        m_tuser,   // end_of_frame
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int CFW   = bb5_pkg::CFG_W;
	localparam int RWI   = bb5_pkg::ROW_W;
	localparam int CW    = ((COL_W > CFW) ? COL_W : CFW) + 2;
	localparam int RW    = RWI + 1;
	localparam logic [CFW-1:0] WIDTH_RST =
		CFW'((MAX_WIDTH < bb5_pkg::WIDTH_RST) ? MAX_WIDTH : bb5_pkg::WIDTH_RST);
	localparam logic [RWI-1:0] HALF_ROW = RWI'(bb5_pkg::HALF);

	logic [CFW-1:0]   width_q, height_q, width_new, height_new, pw;
	logic [COL_W-1:0] in_col_q, col_cnt_q, col_s1;
	logic [RWI-1:0]   in_row_q, row_cnt_q;
	logic [CW-1:0]    cx, wx, icx;
	logic [RW-1:0]    rx, hx, rcx;

	logic              accept, adv, cfg_wr, in_col_last;
	bb5_pkg::reg_idx_t reg_idx;
	bb5_pkg::rgb_t     pix0, pix_s1;
	bb5_pkg::ctrl_t    ctrl0, ctrl_s1;
	bb5_pkg::col_t     col_data;
	bb5_pkg::res_t     res, out_res;

	assign accept   = s_tvalid && adv;
	assign s_tready = adv;
	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign reg_idx  = bb5_pkg::reg_idx_t'(paddr[2]);
	assign pw       = pwdata[CFW-1:0];

	always_comb begin
		if (CW'(pw) < CW'(bb5_pkg::MIN_DIM)) begin
			width_new  = CFW'(bb5_pkg::MIN_DIM);
			height_new = CFW'(bb5_pkg::MIN_DIM);
		end else begin
			width_new  = (CW'(pw) > CW'(MAX_WIDTH)) ? CFW'(MAX_WIDTH) : pw;
			height_new = (CW'(pw) > CW'(bb5_pkg::MAX_HEIGHT)) ?
				CFW'(bb5_pkg::MAX_HEIGHT) : pw;
		end
	end

	always_comb begin
		case (reg_idx)
			bb5_pkg::REG_WIDTH: begin
				prdata = 32'(width_q);
			end
			bb5_pkg::REG_HEIGHT: begin
				prdata = 32'(height_q);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	assign cx  = CW'(col_cnt_q);
	assign wx  = CW'(width_q);
	assign icx = CW'(in_col_q);
	assign rx  = RW'(in_row_q);
	assign hx  = RW'(height_q);
	assign rcx = RW'(row_cnt_q);

	assign pix0        = s_tuser ? '0 : bb5_pkg::rgb_t'(s_tdata);
	assign in_col_last = (icx + CW'(1) == wx);

	always_comb begin
		ctrl0.valid = 1'b1;
		ctrl0.emit  = (in_row_q > HALF_ROW) ||
			((in_row_q == HALF_ROW) && (icx >= CW'(bb5_pkg::HALF)));
		ctrl0.eor   = (cx + CW'(1) == wx);
		ctrl0.eof   = ctrl0.eor && (rcx + RW'(1) == hx);
		// tap j carries column col_cnt + HALF - j
		for (int j = 0; j < bb5_pkg::WIN; j++) begin
			ctrl0.hmask[j] = (cx + CW'(bb5_pkg::HALF) >= CW'(j)) &&
				(cx + CW'(bb5_pkg::HALF) < wx + CW'(j));
		end
		// lane k carries row in_row - k
		for (int k = 0; k < bb5_pkg::WIN; k++) begin
			ctrl0.vmask[k] = (rx >= RW'(k)) && (rx < hx + RW'(k));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= WIDTH_RST;
			height_q  <= CFW'(bb5_pkg::HEIGHT_RST);
			in_col_q  <= '0;
			in_row_q  <= '0;
			col_cnt_q <= '0;
			row_cnt_q <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				bb5_pkg::REG_WIDTH: begin
					width_q <= width_new;
				end
				bb5_pkg::REG_HEIGHT: begin
					height_q <= height_new;
				end
				default: begin
				end
			endcase
			in_col_q  <= '0;
			in_row_q  <= '0;
			col_cnt_q <= '0;
			row_cnt_q <= '0;
		end else if (accept) begin
			if (ctrl0.emit && ctrl0.eof) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				col_cnt_q <= '0;
				row_cnt_q <= '0;
			end else begin
				if (ctrl0.emit) begin
					if (ctrl0.eor) begin
						col_cnt_q <= '0;
						row_cnt_q <= row_cnt_q + RWI'(1);
					end else begin
						col_cnt_q <= col_cnt_q + COL_W'(1);
					end
				end
				if (in_col_last) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + RWI'(1);
				end else begin
					in_col_q <= in_col_q + COL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else if (adv) begin
			ctrl_s1 <= accept ? ctrl0 : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= pix0;
			col_s1 <= in_col_q;
		end
	end

	bb5_line_store #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_line_store (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (accept),
		.rd_addr(in_col_q),
		.wr_en  (adv && ctrl_s1.valid),
		.wr_addr(col_s1),
		.wr_pix (pix_s1),
		.rd_col (col_data)
	);

	bb5_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.ctrl_s1 (ctrl_s1),
		.pix_s1  (pix_s1),
		.col_data(col_data),
		.res     (res)
	);

	bb5_out_skid u_out_skid (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_res  (res),
		.in_ready(adv),
		.m_ready (m_tready),
		.out_res (out_res)
	);

	assign m_tvalid = out_res.valid;
	assign m_tdata  = out_res.rgb;
	assign m_tlast  = out_res.eor;
	assign m_tuser  = out_res.eof;

	a_in_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		icx < wx)
		else $error("input column beyond image width");

	a_in_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		rx <= hx + RW'(bb5_pkg::HALF))
		else $error("input row beyond drain rows");

endmodule

// ----- test/blur_check_pkg.sv -----
// ----------------------------------------------------------------------------
// blur_check_pkg
// Pixel-accurate prediction of the 5x5 box blur and a checker for its output
// beats. Expected pixels are computed when an input beat is accepted and
// queued in order. Each output beat is compared with the oldest one.
// ----------------------------------------------------------------------------
package blur_check_pkg;

	import bb5_pkg::*;

	localparam int STORE_W = 1024;
	localparam int MAX_PRINTS = 30;

	typedef struct {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic            eor;
		logic            eof;
	} blur_px_t;

	class blur_scoreboard;
		logic [23:0] line_mem [WIN*STORE_W];
		int unsigned img_w;
		int unsigned img_h;
		int unsigned out_col;
		int unsigned out_row;
		int unsigned in_col;
		int unsigned in_row;
		blur_px_t    blur_q [$];
		int          errors;

		function new();
			img_w  = WIDTH_RST;
			img_h  = HEIGHT_RST;
			errors = 0;
			rewind();
		endfunction

		function void rewind();
			out_col = 0;
			out_row = 0;
			in_col  = 0;
			in_row  = 0;
		endfunction

		function int unsigned fit_dim(logic [31:0] v, int unsigned hi);
			int unsigned x;
			x = v[CFG_W-1:0];
			if (x < MIN_DIM) return MIN_DIM;
			if (x > hi) return hi;
			return x;
		endfunction

		function int unsigned slot(int unsigned row, int unsigned col);
			return (row % WIN) * STORE_W + (col % STORE_W);
		endfunction

		function void write_reg(logic [2:0] addr, logic [31:0] data);
			reg_idx_t idx;
			idx = reg_idx_t'(addr[2]);
			if (idx == REG_WIDTH) begin
				img_w = fit_dim(data, STORE_W);
			end else begin
				img_h = fit_dim(data, MAX_HEIGHT);
			end
			rewind();
		endfunction

		function int pending();
			return blur_q.size();
		endfunction

		// flush inside the frame is a black pixel
		function void note_beat(logic [23:0] data, logic flush);
			logic [23:0] px;
			logic [23:0] v;
			int unsigned sum_r, sum_g, sum_b;
			int          dy, dx, y, x;
			bit          fire, eor, eof;
			blur_px_t    r;
			px = flush ? '0 : data;
			line_mem[slot(in_row, in_col)] = px;
			fire = in_row > HALF || (in_row == HALF && in_col >= HALF);
			if (fire) begin
				eor = (out_col == img_w - 1);
				eof = eor && (out_row == img_h - 1);
				sum_r = 0;
				sum_g = 0;
				sum_b = 0;
				for (dy = -HALF; dy <= HALF; dy++) begin
					for (dx = -HALF; dx <= HALF; dx++) begin
						y = int'(out_row) + dy;
						x = int'(out_col) + dx;
						v = '0;
						if (y >= 0 && y < int'(img_h) && x >= 0 && x < int'(img_w))
							v = line_mem[slot(y, x)];
						sum_r += v[7:0];
						sum_g += v[15:8];
						sum_b += v[23:16];
					end
				end
				r.red   = CH_W'(sum_r / (WIN*WIN));
				r.green = CH_W'(sum_g / (WIN*WIN));
				r.blue  = CH_W'(sum_b / (WIN*WIN));
				r.eor   = eor;
				r.eof   = eof;
				blur_q.push_back(r);
				if (eof) begin
					rewind();
					return;
				end
				if (eor) begin
					out_col = 0;
					out_row++;
				end else begin
					out_col++;
				end
			end
			in_col++;
			if (in_col >= img_w) begin
				in_col = 0;
				in_row++;
			end
		endfunction

		task report(string msg);
			errors++;
			if (errors <= MAX_PRINTS) $display("mismatch: %s", msg);
		endtask

		task check_result(logic [23:0] data, logic last, logic user);
			blur_px_t w;
			if (blur_q.size() == 0) begin
				report($sformatf("output beat %h with nothing pending", data));
				return;
			end
			w = blur_q.pop_front();
			if (data[7:0] !== w.red)
				report($sformatf("red got %0d want %0d", data[7:0], w.red));
			if (data[15:8] !== w.green)
				report($sformatf("green got %0d want %0d", data[15:8], w.green));
			if (data[23:16] !== w.blue)
				report($sformatf("blue got %0d want %0d", data[23:16], w.blue));
			if (last !== w.eor)
				report($sformatf("end_of_row got %b want %b", last, w.eor));
			if (user !== w.eof)
				report($sformatf("end_of_frame got %b want %b", user, w.eof));
		endtask
	endclass

endpackage

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Stream testbench for the 5x5 box blur block.
//
// Configures frame size over APB, then sends a directed frame, a frame at the
// largest height cut short, and random frames of small sizes with
// flush-as-black pixels, pixels in the drain and frames cut short by a
// register write. Input bursts and output stalls are random; a long output
// hold-off fills the block. Every output beat is checked against a predicted
// blur.
// ----------------------------------------------------------------------------
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	import bb5_pkg::*;
	import blur_check_pkg::*;

	localparam int IDLE_LIMIT   = 2000;
	localparam int SETTLE       = 12;
	localparam int RANDOM_BEATS = 1150;
	localparam int TALL_BEATS   = 60;
	localparam int HOLD_AFTER   = 200;
	localparam int HOLD_CYCLES  = 300;

	typedef enum int {
		RX_FREE,
		RX_MOSTLY_READY,
		RX_EVERY_THIRD,
		RX_MOSTLY_STALLED
	} rx_mode_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata  = '0;
	logic        s_tuser  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	blur_scoreboard sb = new();

	int burst_left   = 1;
	int results_seen = 0;
	int idle_cycles  = 0;
	bit held_off     = 1'b0;

	box_blur_5x5_stream_top #(
		.MAX_WIDTH(STORE_W)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (s_tvalid && s_tready) sb.note_beat(s_tdata, s_tuser);
		if (m_tvalid && m_tready) begin
			sb.check_result(m_tdata, m_tlast, m_tuser);
			results_seen++;
		end
		if (psel && penable && pwrite && pready) sb.write_reg(paddr, pwdata);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// output side: changing stall pattern, one long hold-off
	initial begin : receiver
		rx_mode_t mode;
		int       left;
		int       tick;
		mode = RX_FREE;
		left = 0;
		tick = 0;
		forever begin
			@(posedge clk);
			if (!held_off && results_seen >= HOLD_AFTER && s_tvalid) begin
				held_off = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (left == 0) begin
					mode = rx_mode_t'($urandom_range(RX_FREE, RX_MOSTLY_STALLED));
					left = $urandom_range(32, 256);
				end
				left--;
				tick++;
				case (mode)
					RX_FREE:         m_tready <= 1'b1;
					RX_MOSTLY_READY: m_tready <= ($urandom_range(0, 9) < 7);
					RX_EVERY_THIRD:  m_tready <= (tick % 3 != 0);
					default:         m_tready <= ($urandom_range(0, 9) < 3);
				endcase
			end
		end
	end

	task automatic pause_sender(int n);
		s_tvalid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic push_beat(logic [23:0] d, logic f);
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		s_tuser  <= f;
		do @(posedge clk); while (!s_tready);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
			                                         : $urandom_range(1, 40);
			if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 12));
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_cfg(reg_idx_t idx, logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// one frame plus its drain, or a random prefix of it when cut
	task automatic run_frame(int w, int h, bit cut, inout int count);
		int          total;
		int          cut_at;
		int          i;
		logic [23:0] d;
		logic        f;
		total  = w * h + 2 * w + 2;
		cut_at = cut ? $urandom_range(1, total - 1) : total;
		for (i = 0; i < cut_at; i++) begin
			d = 24'($urandom);
			if ($urandom_range(0, 9) == 0) d = $urandom_range(0, 1) ? '1 : '0;
			if (i < w * h)
				f = ($urandom_range(0, 19) == 0);
			else
				f = ($urandom_range(0, 7) != 0);
			push_beat(d, f);
			if (i == cut_at / 2 && $urandom_range(0, 9) == 0) wait_drained();
		end
		count += cut_at;
	endtask

	initial begin : stimulus
		int          beats;
		int          w;
		int          h;
		int          i;
		bit          need_cfg;
		bit          cut;
		logic [23:0] d;
		logic        f;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// below-range sizes clamp to 5; upper pwdata bits are ignored
		write_cfg(REG_WIDTH, 32'hFFFF_F800);
		write_cfg(REG_HEIGHT, 32'd3);
		for (i = 0; i < 37; i++) begin
			case (i)
				10:      d = 24'h0000FF;
				11:      d = 24'h00FF00;
				13:      d = 24'hFF0000;
				default: d = (i < 5) ? '1 : (i < 10) ? ((i % 2) ? '1 : '0) : 24'($urandom);
			endcase
			f = (i == 12 || i == 18) ? 1'b1 : (i >= 25 && i % 3 != 0);
			if (f) d = '1;
			push_beat(d, f);
		end
		// next frame starts right away, then a register write cuts it
		for (i = 0; i < 7; i++) push_beat(24'($urandom), 1'b0);
		wait_drained();
		write_cfg(REG_WIDTH, 32'd5);

		// tallest frame, cut short by the next register write
		write_cfg(REG_HEIGHT, 32'hFFFF_FC00);
		for (i = 0; i < TALL_BEATS; i++)
			push_beat(24'($urandom), ($urandom_range(0, 19) == 0));

		beats    = 0;
		need_cfg = 1'b1;
		while (beats < RANDOM_BEATS) begin
			if (need_cfg || $urandom_range(0, 2) == 0) begin
				wait_drained();
				w = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 14);
				h = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 10);
				if (need_cfg || $urandom_range(0, 1))
					write_cfg(REG_WIDTH, {21'($urandom), 11'(w)});
				if ($urandom_range(0, 1))
					write_cfg(REG_HEIGHT, {21'($urandom), 11'(h)});
			end
			cut = ($urandom_range(0, 7) == 0);
			run_frame(sb.img_w, sb.img_h, cut, beats);
			need_cfg = cut;
		end

		wait_drained();
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- box_blur_5x5_stream_top.f -----
design/bb5_pkg.sv
design/bb5_line_store.sv
design/bb5_window.sv
design/bb5_out_skid.sv
design/box_blur_5x5_stream_top.sv
test/blur_check_pkg.sv
test/tb_top.sv
